// File: src/vpms_pkg.sv
// ----------------------------------------------------------------------------
// vpms_pkg: shared types and constants of the vehicle power mode sequencer
// Mode codes, register indexes, reset values and the word types of the
// input and result channels.
// ----------------------------------------------------------------------------
package vpms_pkg;

  // Power mode codes, as shown on mode_code
  localparam logic [2:0] MODE_OFF = 3'd0;
  localparam logic [2:0] MODE_ACC = 3'd1;
  localparam logic [2:0] MODE_IGN = 3'd2;
  localparam logic [2:0] MODE_EV  = 3'd3;
  localparam logic [2:0] MODE_ENG = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ENG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENG_STOP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_TMO   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IGN_TMO   = 2'd3;

  // Register reset values
  localparam logic [7:0]  ENG_START_RST = 8'd20;
  localparam logic [7:0]  ENG_STOP_RST  = 8'd0;
  localparam logic [15:0] ACC_TMO_RST   = 16'd5000;
  localparam logic [15:0] IGN_TMO_RST   = 16'd10000;

  // Default countdown width
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  typedef struct packed {
    logic       switch_pressed;
    logic       switch_changed;
    logic       shift_in_park;
    logic       brake_applied;
    logic [7:0] pedal_level;
  } in_word_t;

  typedef struct packed {
    logic [7:0] drive_level;
    logic       meter_enabled;
    logic [7:0] meter_value;
    logic       info_enabled;
    logic [2:0] mode_code;
    logic       ready_shown;
    logic       gear_letter_drive;
  } out_word_t;

endpackage

// File: src/vehicle_power_mode_sequencer.sv
// ----------------------------------------------------------------------------
// vehicle_power_mode_sequencer: power mode and auto-off sequencer
// Takes one tick word per item and returns one status word per item.
// ----------------------------------------------------------------------------
// Path: the input register takes each accepted word and feeds the mode and
//   countdown update, which loads the result register.
// Throughput: one word per cycle; the result register frees each cycle the
//   result side takes a word, so input and output stall only on out_ready.
// Reset (rst_n low, synchronous): mode off, countdown zero, registers at
//   their default values, both pipeline stages empty.
module vehicle_power_mode_sequencer
  import vpms_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  // configuration port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Largest value the countdown holds; timeouts above it saturate.
  localparam longint unsigned CntMax = (64'd1 << COUNT_WIDTH) - 64'd1;
  localparam logic [31:0] CntMax32 = CntMax[31:0];

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0]  eng_start_r;
  logic [7:0]  eng_stop_r;
  logic [15:0] acc_tmo_r;
  logic [15:0] ign_tmo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eng_start_r <= ENG_START_RST;
      eng_stop_r  <= ENG_STOP_RST;
      acc_tmo_r   <= ACC_TMO_RST;
      ign_tmo_r   <= IGN_TMO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENG_START: eng_start_r <= cfg_wdata[7:0];
        REG_ENG_STOP:  eng_stop_r  <= cfg_wdata[7:0];
        REG_ACC_TMO:   acc_tmo_r   <= cfg_wdata;
        REG_IGN_TMO:   ign_tmo_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Countdown reload values, saturated to the countdown width
  logic [31:0]            acc_tmo_ext;
  logic [31:0]            ign_tmo_ext;
  logic [COUNT_WIDTH-1:0] acc_load;
  logic [COUNT_WIDTH-1:0] ign_load;

  assign acc_tmo_ext = {16'd0, acc_tmo_r};
  assign ign_tmo_ext = {16'd0, ign_tmo_r};
  assign acc_load = (acc_tmo_ext > CntMax32) ? CntMax32[COUNT_WIDTH-1:0]
                                             : acc_tmo_ext[COUNT_WIDTH-1:0];
  assign ign_load = (ign_tmo_ext > CntMax32) ? CntMax32[COUNT_WIDTH-1:0]
                                             : ign_tmo_ext[COUNT_WIDTH-1:0];

  // --------------------------------------------------------------------------
  // Pipeline control: input register feeds the result register
  // --------------------------------------------------------------------------
  logic      s1_valid_r, s1_valid_nxt;
  in_word_t  s1_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;
  logic      in_fire;
  logic      advance;

  // Move the held word on when the result register is empty or being taken.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Mode and countdown update for the word in the input register
  // --------------------------------------------------------------------------
  logic [2:0]             mode_r, mode_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [2:0]             mode_cur;
  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic [COUNT_WIDTH-1:0] cnt_mid;
  logic                   cnt_zero;
  logic [7:0]             speed;
  logic                   full_on;
  logic                   sw_on;
  logic                   evt;
  logic                   park;

  assign sw_on   = s1_data_r.switch_pressed;
  assign evt     = s1_data_r.switch_changed;
  assign park    = s1_data_r.shift_in_park;
  // Speed reads as zero with the brake on or the shift in park.
  assign speed   = (s1_data_r.brake_applied || park) ? 8'd0 : s1_data_r.pedal_level;
  assign full_on = sw_on && park && s1_data_r.brake_applied;

  // Treat a mode code without meaning as off.
  assign mode_cur = (mode_r > MODE_ENG) ? MODE_OFF : mode_r;

  // Decrement, stop at zero.
  assign cnt_dec = (cnt_r != '0) ? (cnt_r - 1'b1) : cnt_r;

  // Result word from the mode held at the start of the tick, plus the
  // reload that accessory and ignition-on apply while out of park.
  always_comb begin
    cnt_mid      = cnt_dec;
    out_data_nxt = '0;
    out_data_nxt.info_enabled      = 1'b1;
    out_data_nxt.gear_letter_drive = !park;
    unique case (mode_cur)
      MODE_ACC: begin
        out_data_nxt.mode_code = MODE_ACC;
        if (!park) begin
          cnt_mid = acc_load;
        end
      end
      MODE_IGN: begin
        out_data_nxt.mode_code     = MODE_IGN;
        out_data_nxt.meter_enabled = 1'b1;
        if (!park) begin
          cnt_mid = ign_load;
        end
      end
      MODE_EV, MODE_ENG: begin
        out_data_nxt.mode_code     = mode_cur;
        out_data_nxt.drive_level   = speed;
        out_data_nxt.meter_enabled = 1'b1;
        out_data_nxt.meter_value   = speed;
        out_data_nxt.ready_shown   = 1'b1;
      end
      default: begin
        out_data_nxt.info_enabled = 1'b0;
      end
    endcase
  end

  assign cnt_zero = (cnt_mid == '0);

  // Mode transition; switch events win over expiry and speed checks.
  always_comb begin
    mode_nxt = mode_cur;
    cnt_nxt  = cnt_mid;
    unique case (mode_cur)
      MODE_OFF: begin
        if (evt && full_on) begin
          mode_nxt = MODE_EV;
        end else if (evt && sw_on) begin
          cnt_nxt  = acc_load;
          mode_nxt = MODE_ACC;
        end
      end
      MODE_ACC: begin
        if (evt) begin
          if (full_on) begin
            mode_nxt = MODE_EV;
          end else if (sw_on) begin
            cnt_nxt  = ign_load;
            mode_nxt = MODE_IGN;
          end
        end else if (cnt_zero) begin
          mode_nxt = MODE_OFF;
        end
      end
      MODE_IGN: begin
        if (evt) begin
          if (full_on || sw_on) begin
            mode_nxt = full_on ? MODE_EV : MODE_OFF;
          end
        end else if (cnt_zero) begin
          mode_nxt = MODE_OFF;
        end
      end
      MODE_EV: begin
        if (evt) begin
          if (full_on) begin
            mode_nxt = MODE_OFF;
          end
        end else if (speed >= eng_start_r) begin
          mode_nxt = MODE_ENG;
        end
      end
      default: begin
        // engine drive
        if (evt) begin
          if (full_on) begin
            mode_nxt = MODE_OFF;
          end
        end else if (speed <= eng_stop_r) begin
          mode_nxt = MODE_EV;
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_OFF;
      cnt_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        mode_r <= mode_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  // Payload: hold unless a new word moves in.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: src/vpms_checker.sv
// ----------------------------------------------------------------------------
// vpms_checker: port-level checks of the power mode sequencer
// Watches the result channel and reset, attached by bind.
// ----------------------------------------------------------------------------
module vpms_checker
  import vpms_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // empty result channel right after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed or dropped");

  // off mode shows nothing but the gear letter
  a_off_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.info_enabled |->
      out_data.mode_code == MODE_OFF && out_data.drive_level == 8'd0 &&
      !out_data.meter_enabled && !out_data.ready_shown)
    else $error("display or drive active in off mode");

  // READY exactly in the drive modes, drive only there
  a_ready_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.ready_shown ==
      (out_data.mode_code == MODE_EV || out_data.mode_code == MODE_ENG) &&
      (out_data.ready_shown || out_data.drive_level == 8'd0))
    else $error("READY or drive level disagrees with mode");

  // meter follows drive level, zero while in park
  a_meter_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.meter_value == out_data.drive_level &&
      (out_data.gear_letter_drive || out_data.drive_level == 8'd0))
    else $error("meter value disagrees with drive level");

endmodule

bind vehicle_power_mode_sequencer vpms_checker u_vpms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the vehicle power mode sequencer
// Feeds tick words through the valid/ready input channel and checks every
// status word against an in-bench model of the power mode and auto-off
// countdown. Covers directed mode walks, countdown expiry, register
// extremes, random drive cycles with random idling, and a long result stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import vpms_pkg::*;

  localparam int unsigned CNT_W = COUNT_WIDTH_DEF;

  // --------------------------------------------------------------------------
  // DUT connections; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ENG_START;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  vehicle_power_mode_sequencer #(
    .COUNT_WIDTH(CNT_W)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  // Slowest correct run is well under half a millisecond; allow ten times that.
  initial begin
    #5ms;
    $display("[vehicle_power_mode_sequencer] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Model of the block: shadow registers, mode and countdown
  // --------------------------------------------------------------------------
  logic [7:0]       eng_start_r = ENG_START_RST;
  logic [7:0]       eng_stop_r  = ENG_STOP_RST;
  logic [15:0]      acc_tmo_r   = ACC_TMO_RST;
  logic [15:0]      ign_tmo_r   = IGN_TMO_RST;
  logic [2:0]       mode_q      = MODE_OFF;
  logic [CNT_W-1:0] count_q     = '0;

  out_word_t status_q[$];   // status words still owed by the DUT
  int        n_errors   = 0;
  int        words_sent = 0;
  int        hold_req   = 0;  // cycles the result side must hold off
  int        tx_run     = 0;  // remaining back-to-back words, input side
  int        rx_run     = 0;  // remaining back-to-back words, result side

  // Clip a timeout to what the countdown can hold.
  function automatic logic [CNT_W-1:0] clamp_count(input logic [15:0] tmo);
    logic [63:0] cmax;
    logic [31:0] t32;
    cmax = (64'd1 << CNT_W) - 64'd1;
    t32  = {16'd0, tmo};
    if ({32'd0, t32} > cmax) return cmax[CNT_W-1:0];
    return t32[CNT_W-1:0];
  endfunction

  // Advance the model by one tick and return the status word it produces.
  function automatic out_word_t predict_status(input in_word_t w);
    logic [7:0] speed;
    logic       full_on;
    logic       chg;
    logic [2:0] m;
    out_word_t  r;
    speed   = (w.brake_applied || w.shift_in_park) ? 8'd0 : w.pedal_level;
    full_on = w.switch_pressed && w.shift_in_park && w.brake_applied;
    chg     = w.switch_changed;
    m       = (mode_q > MODE_ENG) ? MODE_OFF : mode_q;

    // countdown runs first and sticks at zero
    if (count_q != '0) count_q = count_q - 1'b1;

    // outputs follow the mode held at the start of the tick
    r = '0;
    r.info_enabled = 1'b1;
    case (m)
      MODE_ACC: begin
        r.mode_code = MODE_ACC;
        if (!w.shift_in_park) count_q = clamp_count(acc_tmo_r);
      end
      MODE_IGN: begin
        r.mode_code     = MODE_IGN;
        r.meter_enabled = 1'b1;
        if (!w.shift_in_park) count_q = clamp_count(ign_tmo_r);
      end
      MODE_EV, MODE_ENG: begin
        r.mode_code     = m;
        r.drive_level   = speed;
        r.meter_enabled = 1'b1;
        r.meter_value   = speed;
        r.ready_shown   = 1'b1;
      end
      default: begin
        r.info_enabled = 1'b0;
      end
    endcase
    r.gear_letter_drive = !w.shift_in_park;

    // mode transition, using the countdown after any reload
    case (m)
      MODE_OFF: begin
        if (chg && full_on) begin
          m = MODE_EV;
        end else if (chg && w.switch_pressed) begin
          count_q = clamp_count(acc_tmo_r);
          m       = MODE_ACC;
        end
      end
      MODE_ACC: begin
        if (chg) begin
          if (full_on) begin
            m = MODE_EV;
          end else if (w.switch_pressed) begin
            count_q = clamp_count(ign_tmo_r);
            m       = MODE_IGN;
          end
        end else if (count_q == '0) begin
          m = MODE_OFF;
        end
      end
      MODE_IGN: begin
        if (chg) begin
          if (full_on) m = MODE_EV;
          else if (w.switch_pressed) m = MODE_OFF;
        end else if (count_q == '0) begin
          m = MODE_OFF;
        end
      end
      MODE_EV: begin
        if (chg) begin
          if (full_on) m = MODE_OFF;
        end else if (speed >= eng_start_r) begin
          m = MODE_ENG;
        end
      end
      default: begin
        if (chg) begin
          if (full_on) m = MODE_OFF;
        end else if (speed <= eng_stop_r) begin
          m = MODE_EV;
        end
      end
    endcase
    mode_q = m;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic in_word_t tick(input logic sw, input logic chg, input logic park,
                                    input logic brake, input logic [7:0] pedal);
    in_word_t w;
    w.switch_pressed = sw;
    w.switch_changed = chg;
    w.shift_in_park  = park;
    w.brake_applied  = brake;
    w.pedal_level    = pedal;
    return w;
  endfunction

  // Idle cycles before the next word; now and then a run of back-to-back words.
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      run_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // Pedal values bunched near the speed thresholds and the ends of the range.
  function automatic logic [7:0] rand_pedal();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 3));
      1:       return 8'($urandom_range(0, 40));
      2:       return 8'(255 - $urandom_range(0, 3));
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one tick word, hold it until taken, then log what it must produce.
  task automatic send_word(input in_word_t w);
    int   gap;
    logic taken;
    gap = draw_wait(tx_run);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    taken = 1'b0;
    // look at ready mid-cycle, where nothing moves, then step to the edge
    while (!taken) begin
      @(negedge clk);
      taken = (in_ready === 1'b1);
      @(posedge clk);
    end
    status_q.push_back(predict_status(w));
    words_sent++;
  endtask

  // Drop valid and wait until every status word owed has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Write all four registers back to back; only called with the DUT drained.
  task automatic write_regs(input logic [7:0] start, input logic [7:0] stop,
                            input logic [15:0] acc, input logic [15:0] ign);
    logic [7:0] junk;
    junk = 8'($urandom);
    // upper byte of the speed registers carries junk the DUT must drop
    cfg_we    <= 1'b1;
    cfg_index <= REG_ENG_START;
    cfg_wdata <= {junk, start};
    @(posedge clk);
    cfg_index <= REG_ENG_STOP;
    cfg_wdata <= {~junk, stop};
    @(posedge clk);
    cfg_index <= REG_ACC_TMO;
    cfg_wdata <= acc;
    @(posedge clk);
    cfg_index <= REG_IGN_TMO;
    cfg_wdata <= ign;
    @(posedge clk);
    cfg_we <= 1'b0;
    eng_start_r = start;
    eng_stop_r  = stop;
    acc_tmo_r   = acc;
    ign_tmo_r   = ign;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, long hold on request, field-by-field check
  // --------------------------------------------------------------------------
  task automatic check_status(input out_word_t got);
    out_word_t want;
    logic      bad;
    if (status_q.size() == 0) begin
      n_errors++;
      if (n_errors <= 10)
        $display("%0t: status word %h arrived with nothing expected", $realtime, got);
      return;
    end
    want = status_q.pop_front();
    bad = (got.drive_level       !== want.drive_level)   ||
          (got.meter_enabled     !== want.meter_enabled) ||
          (got.meter_value       !== want.meter_value)   ||
          (got.info_enabled      !== want.info_enabled)  ||
          (got.mode_code         !== want.mode_code)     ||
          (got.ready_shown       !== want.ready_shown)   ||
          (got.gear_letter_drive !== want.gear_letter_drive);
    if (bad) begin
      n_errors++;
      if (n_errors <= 10) begin
        $display("%0t: status mismatch", $realtime);
        $write("  expected drive=%0d meter_en=%0d meter=%0d info=%0d",
               want.drive_level, want.meter_enabled, want.meter_value, want.info_enabled);
        $display(" mode=%0d ready=%0d gear_d=%0d",
                 want.mode_code, want.ready_shown, want.gear_letter_drive);
        $write("  actual   drive=%0d meter_en=%0d meter=%0d info=%0d",
               got.drive_level, got.meter_enabled, got.meter_value, got.info_enabled);
        $display(" mode=%0d ready=%0d gear_d=%0d",
                 got.mode_code, got.ready_shown, got.gear_letter_drive);
      end
    end
  endtask

  initial begin : result_side
    int        stall;
    logic      took;
    out_word_t got;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req > 0) begin
        // hold off for the requested stretch; count it here, cycle by cycle
        out_ready <= 1'b0;
        while (hold_req > 0) begin
          @(posedge clk);
          hold_req--;
        end
      end else begin
        stall = draw_wait(rx_run);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      took = 1'b0;
      while (!took) begin
        @(negedge clk);
        took = (out_valid === 1'b1);
        got  = out_data;
        @(posedge clk);
      end
      check_status(got);
    end
  end

  // --------------------------------------------------------------------------
  // Test tasks
  // --------------------------------------------------------------------------

  // Walk every mode and every switch and speed transition with default registers.
  task automatic test_directed_modes();
    send_word(tick(0, 0, 1, 1, 8'd0));     // off, all quiet
    send_word(tick(1, 1, 0, 0, 8'd255));   // off -> accessory
    send_word(tick(0, 1, 0, 0, 8'd128));   // event with switch off: no change
    send_word(tick(1, 1, 1, 0, 8'd7));     // accessory -> ignition on
    send_word(tick(0, 0, 0, 1, 8'd255));   // ignition on holds, meter on
    send_word(tick(1, 1, 0, 1, 8'd1));     // ignition on -> off
    send_word(tick(1, 1, 1, 1, 8'd255));   // off -> EV on full switch-on
    send_word(tick(0, 0, 1, 1, 8'd255));   // EV in park: drive forced to zero
    send_word(tick(0, 0, 0, 0, 8'd255));   // full pedal, EV -> engine
    send_word(tick(1, 0, 0, 0, 8'd19));    // engine holds above stop speed
    send_word(tick(0, 0, 0, 1, 8'd200));   // brake: speed zero, engine -> EV
    send_word(tick(0, 0, 0, 0, 8'd20));    // speed at start threshold, EV -> engine
    send_word(tick(1, 1, 1, 1, 8'd0));     // engine -> off
    send_word(tick(1, 1, 1, 1, 8'd0));     // off -> EV
    send_word(tick(1, 1, 0, 0, 8'd50));    // event blocks EV -> engine
    send_word(tick(1, 1, 1, 1, 8'd0));     // EV -> off
    send_word(tick(1, 1, 0, 1, 8'd0));     // off -> accessory
    send_word(tick(1, 1, 1, 1, 8'd0));     // accessory -> EV
    send_word(tick(1, 1, 1, 1, 8'd0));     // EV -> off
    send_word(tick(1, 1, 0, 0, 8'd0));     // off -> accessory
    send_word(tick(1, 1, 0, 0, 8'd0));     // accessory -> ignition on
    send_word(tick(1, 1, 1, 1, 8'd0));     // ignition on -> EV
    send_word(tick(0, 1, 1, 1, 8'd0));     // EV, event with switch off
    send_word(tick(1, 1, 1, 1, 8'd170));   // EV -> off
    send_word(tick(0, 0, 0, 0, 8'd85));    // off, gear shows D
    drain_results();
  endtask

  // Short and zero timeouts so the auto-off path fires.
  task automatic test_countdown_expiry();
    write_regs(ENG_START_RST, ENG_STOP_RST, 16'd3, 16'd2);
    send_word(tick(1, 1, 1, 0, 8'd0));              // off -> accessory
    repeat (3) send_word(tick(0, 0, 0, 0, 8'd9));   // out of park: reload each tick
    repeat (5) send_word(tick(0, 0, 1, 0, 8'd0));   // in park: run out -> off
    send_word(tick(1, 1, 1, 0, 8'd0));              // off -> accessory
    send_word(tick(1, 1, 0, 0, 8'd0));              // accessory -> ignition on
    repeat (4) send_word(tick(0, 0, 1, 1, 8'd0));   // ignition on runs out -> off
    send_word(tick(0, 0, 0, 0, 8'd0));
    drain_results();

    write_regs(ENG_START_RST, ENG_STOP_RST, 16'd0, 16'd0);
    send_word(tick(1, 1, 0, 0, 8'd0));   // off -> accessory with zero count
    send_word(tick(0, 0, 0, 0, 8'd0));   // reload of zero: straight to off
    send_word(tick(1, 1, 1, 0, 8'd0));   // off -> accessory
    send_word(tick(0, 1, 1, 0, 8'd0));   // event seen: expiry held back
    send_word(tick(0, 0, 1, 0, 8'd0));   // quiet tick: -> off
    send_word(tick(1, 1, 0, 0, 8'd0));   // off -> accessory
    send_word(tick(1, 1, 0, 1, 8'd0));   // accessory -> ignition on
    send_word(tick(0, 0, 1, 1, 8'd0));   // ignition on -> off
    send_word(tick(0, 0, 1, 1, 8'd0));
    drain_results();
  endtask

  // Mostly well-formed drive cycles and accessory sessions, some raw noise.
  task automatic test_random_traffic(input logic [7:0] start, input logic [7:0] stop,
                                     input logic [15:0] acc, input logic [15:0] ign,
                                     input int n_words);
    int first;
    int len;
    int pick;
    first = words_sent;
    write_regs(start, stop, acc, ign);
    while (words_sent - first < n_words) begin
      pick = $urandom_range(0, 19);
      len  = $urandom_range(4, 40);
      if (pick < 12) begin
        // drive cycle: switch on, drive, switch off
        send_word(tick(1, 1, 1, 1, 8'($urandom)));
        repeat (len) begin
          send_word(tick(1'($urandom), $urandom_range(0, 19) == 0,
                         $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                         rand_pedal()));
        end
        send_word(tick(1, 1, 1, 1, 8'($urandom)));
      end else if (pick < 17) begin
        // accessory session: enter without full switch-on, mostly park, let it lapse
        send_word(tick(1, 1, 1'($urandom), 1'b0, 8'($urandom)));
        repeat (len) begin
          send_word(tick(1'($urandom), $urandom_range(0, 9) == 0,
                         $urandom_range(0, 3) != 0, 1'($urandom), 8'($urandom)));
        end
      end else begin
        repeat (len) send_word(in_word_t'(12'($urandom)));
      end
    end
    drain_results();
  endtask

  // Hold the result side for a long stretch while words keep coming.
  task automatic test_input_stall();
    hold_req = 300;
    send_word(tick(1, 1, 1, 1, 8'd0));
    repeat (40) begin
      send_word(tick(1'($urandom), $urandom_range(0, 15) == 0, 1'($urandom),
                     1'($urandom), rand_pedal()));
    end
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Sequence of the run
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_modes();
    test_countdown_expiry();
    test_random_traffic(ENG_START_RST, ENG_STOP_RST, ACC_TMO_RST, IGN_TMO_RST, 130);
    test_random_traffic(8'd0, 8'd0, 16'd0, 16'd0, 130);
    test_random_traffic(8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 130);
    test_random_traffic(8'd0, 8'd255, 16'd1, 16'd2, 130);
    test_random_traffic(8'($urandom), 8'($urandom), 16'($urandom_range(0, 6)),
                        16'($urandom_range(0, 6)), 130);
    test_random_traffic(8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)),
                        16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)), 130);
    test_input_stall();

    // allow for a stray word behind the two pipeline stages
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("[vehicle_power_mode_sequencer] OK");
    end else begin
      $display("[vehicle_power_mode_sequencer] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
src/vpms_pkg.sv
src/vehicle_power_mode_sequencer.sv
src/vpms_checker.sv
tb/tb_top.sv
